// ===== rtl/fgr_pkg.sv =====
// Shared types and constants of the font glyph rasterizer.
// Holds the item structs, the configuration struct, the codes and the sequencer states.
// No dependencies.
package fgr_pkg;

   localparam int FONT_BYTES  = 4096;
   localparam int FONT_AW     = 12;
   localparam int MASK_BITS   = 32;
   localparam int WIDTH_CAP   = 32;
   localparam int HEIGHT_CAP  = 32;
   localparam int SCREEN_SIZE = 96;
   localparam int CSR_AW      = 5;
   localparam int CSR_DW      = 32;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_CURSOR = 2'd1;
   localparam logic [1:0] OP_DRAW   = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_CODE = 2'd1;
   localparam logic [1:0] STATUS_CURSOR  = 2'd2;
   localparam logic [1:0] STATUS_CLIPPED = 2'd3;

   localparam logic [1:0] ORIENT_HORIZ = 2'd0;
   localparam logic [1:0] ORIENT_STACK = 2'd2;

   localparam logic [2:0] REG_TEXT_COLOR   = 3'd0;
   localparam logic [2:0] REG_ORIENTATION  = 3'd1;
   localparam logic [2:0] REG_FIRST_CODE   = 3'd2;
   localparam logic [2:0] REG_LAST_CODE    = 3'd3;
   localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd4;

   localparam logic [15:0] ENTRY_BASE = 16'd8;

   typedef struct packed {
      logic [1:0]  operation;
      logic [11:0] font_addr;
      logic [7:0]  font_byte;
      logic [7:0]  char_code;
      logic [15:0] set_x;
      logic [15:0] set_y;
   } req_type;

   typedef struct packed {
      logic [15:0] origin_col;
      logic [15:0] origin_row;
      logic        step_down_rows;
      logic [31:0] pixel_mask;
      logic [15:0] pixel_color;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] text_color;
      logic [1:0]  orientation;
      logic [7:0]  first_code;
      logic [7:0]  last_code;
      logic [5:0]  glyph_height;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ENTRY,
      ST_ROW,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/fgr_csr.sv =====
// Configuration register file of the font glyph rasterizer with its APB-style port.
// Depends on fgr_pkg for the configuration struct and the register indexes.
module fgr_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [fgr_pkg::CSR_AW-1:0]  paddr,
   input  logic [fgr_pkg::CSR_DW-1:0]  pwdata,
   output logic [fgr_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output fgr_pkg::cfg_type            cfg
);

   fgr_pkg::cfg_type cfg_ff;
   fgr_pkg::cfg_type cfg_in;
   logic [2:0]       reg_index;
   logic             wr_en;

   assign reg_index = paddr[4:2];
   assign wr_en     = psel & penable & pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            fgr_pkg::REG_TEXT_COLOR:   cfg_in.text_color   = pwdata[15:0];
            fgr_pkg::REG_ORIENTATION:  cfg_in.orientation  = pwdata[1:0];
            fgr_pkg::REG_FIRST_CODE:   cfg_in.first_code   = pwdata[7:0];
            fgr_pkg::REG_LAST_CODE:    cfg_in.last_code    = pwdata[7:0];
            fgr_pkg::REG_GLYPH_HEIGHT: cfg_in.glyph_height = pwdata[5:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         fgr_pkg::REG_TEXT_COLOR:   prdata = {16'd0, cfg_ff.text_color};
         fgr_pkg::REG_ORIENTATION:  prdata = {30'd0, cfg_ff.orientation};
         fgr_pkg::REG_FIRST_CODE:   prdata = {24'd0, cfg_ff.first_code};
         fgr_pkg::REG_LAST_CODE:    prdata = {24'd0, cfg_ff.last_code};
         fgr_pkg::REG_GLYPH_HEIGHT: prdata = {26'd0, cfg_ff.glyph_height};
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.text_color   <= 16'd0;
         cfg_ff.orientation  <= 2'd0;
         cfg_ff.first_code   <= 8'd32;
         cfg_ff.last_code    <= 8'd126;
         cfg_ff.glyph_height <= 6'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/font_glyph_rasterizer_unit.sv =====
// Top level of the font glyph rasterizer: font memory, cursor and row sequencer.
// Depends on fgr_pkg and instantiates fgr_csr.
//
//   channel   ports                         direction   content
//   req       req_valid/req_stall/req_data  in          load, set cursor or draw item
//   rsp       rsp_valid/rsp_stall/rsp_data  out         one glyph row mask or status
//   config    psel ... prdata, pready       in/out      five registers, 32-bit data
//
// Load, set cursor and rejected draw items are each finished without leaving the idle state.
// A draw item first reads its glyph entry, then the ceil(w/8) bytes of each row
// (w = clipped width, at most 32, so at most four bytes a row), all paced by the single
// read port of the font memory.
// Synchronous reset clears the cursor, its valid flag and the control state; font memory
// contents are undefined until loaded. A stalled output holds the emit state in place.
module font_glyph_rasterizer_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  fgr_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output fgr_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [fgr_pkg::CSR_AW-1:0]  paddr,
   input  logic [fgr_pkg::CSR_DW-1:0]  pwdata,
   output logic [fgr_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);

   fgr_pkg::cfg_type   cfg;

   logic [7:0]                  font_mem [fgr_pkg::FONT_BYTES];
   logic [7:0]                  mem_q_ff;
   logic [fgr_pkg::FONT_AW-1:0] rd_addr;
   logic                        mem_we;

   fgr_pkg::state_type state_ff, state_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [5:0]  row_ff, row_in;
   logic [fgr_pkg::FONT_AW-1:0] entry_ptr_ff, entry_ptr_in;
   logic [fgr_pkg::FONT_AW-1:0] row_ptr_ff, row_ptr_in;
   logic [7:0]  raw_w_ff, raw_w_in;
   logic [7:0]  base_lo_ff, base_lo_in;
   logic [5:0]  width_ff, width_in;
   logic [2:0]  nbytes_ff, nbytes_in;
   logic [5:0]  stride_ff, stride_in;
   logic [5:0]  height_ff, height_in;
   logic        clipped_ff, clipped_in;
   logic [31:0] bits_ff, bits_in;
   logic [15:0] cur_col_ff, cur_col_in;
   logic [15:0] cur_row_ff, cur_row_in;
   logic        cur_valid_ff, cur_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   fgr_pkg::rsp_type rsp_ff, rsp_in;

   logic        out_free;
   logic        accept;
   logic        rotated;
   logic [15:0] col0, row0;
   logic [31:0] clip_mask;
   logic [31:0] width_mask;
   logic [32:0] width_mask_wide;
   logic [8:0]  raw_w_round;
   logic [1:0]  byte_idx;
   logic        row_last;

   fgr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == fgr_pkg::ST_IDLE && out_free);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign mem_we    = accept && req_data.operation == fgr_pkg::OP_LOAD;

   assign rotated = cfg.orientation != fgr_pkg::ORIENT_HORIZ &&
                    cfg.orientation != fgr_pkg::ORIENT_STACK;
   assign col0 = rotated ? cur_col_ff + 16'(row_ff) : cur_col_ff;
   assign row0 = rotated ? cur_row_ff : cur_row_ff + 16'(row_ff);

   assign width_mask_wide = (33'd1 << width_ff) - 33'd1;
   assign width_mask      = width_mask_wide[31:0];
   assign raw_w_round     = {1'b0, raw_w_ff} + 9'd7;
   assign byte_idx        = 2'(cnt_ff - 3'd1);
   assign row_last        = height_ff == 6'd0 || row_ff + 6'd1 == height_ff;

   always_comb begin
      logic [15:0] pc;
      logic [15:0] pr;
      for (int k = 0; k < fgr_pkg::MASK_BITS; k++) begin
         pc = rotated ? col0 : col0 + 16'(k);
         pr = rotated ? row0 - 16'(k) : row0;
         clip_mask[k] = pc < 16'(fgr_pkg::SCREEN_SIZE) && pr < 16'(fgr_pkg::SCREEN_SIZE);
      end
   end

   always_comb begin
      if (state_ff == fgr_pkg::ST_ENTRY) begin
         rd_addr = entry_ptr_ff + fgr_pkg::FONT_AW'(cnt_ff);
      end else begin
         rd_addr = row_ptr_ff + fgr_pkg::FONT_AW'(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         font_mem[req_data.font_addr] <= req_data.font_byte;
      end
      mem_q_ff <= font_mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      entry_ptr_in = entry_ptr_ff;
      row_ptr_in   = row_ptr_ff;
      raw_w_in     = raw_w_ff;
      base_lo_in   = base_lo_ff;
      width_in     = width_ff;
      nbytes_in    = nbytes_ff;
      stride_in    = stride_ff;
      height_in    = height_ff;
      clipped_in   = clipped_ff;
      bits_in      = bits_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      cur_valid_in = cur_valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         fgr_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_in.origin_col     = 16'd0;
               rsp_in.origin_row     = 16'd0;
               rsp_in.step_down_rows = 1'b0;
               rsp_in.pixel_mask     = 32'd0;
               rsp_in.pixel_color    = cfg.text_color;
               rsp_in.last           = 1'b1;
               rsp_in.status         = fgr_pkg::STATUS_OK;
               if (req_data.operation == fgr_pkg::OP_CURSOR) begin
                  rsp_valid_in = 1'b1;
                  if (req_data.set_x >= 16'(fgr_pkg::SCREEN_SIZE) ||
                      req_data.set_y >= 16'(fgr_pkg::SCREEN_SIZE)) begin
                     rsp_in.status = fgr_pkg::STATUS_CURSOR;
                  end else begin
                     cur_col_in   = req_data.set_x;
                     cur_row_in   = req_data.set_y;
                     cur_valid_in = 1'b1;
                  end
               end else if (req_data.operation == fgr_pkg::OP_DRAW) begin
                  if (!cur_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = fgr_pkg::STATUS_CURSOR;
                  end else if (req_data.char_code < cfg.first_code ||
                               req_data.char_code > cfg.last_code) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = fgr_pkg::STATUS_NO_CODE;
                  end else begin
                     entry_ptr_in = fgr_pkg::FONT_AW'(fgr_pkg::ENTRY_BASE) +
                                    {2'd0, req_data.char_code - cfg.first_code, 2'd0};
                     cnt_in   = 3'd0;
                     state_in = fgr_pkg::ST_ENTRY;
                  end
               end
            end
         end

         fgr_pkg::ST_ENTRY: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd1) begin
               raw_w_in = mem_q_ff;
            end
            if (cnt_ff == 3'd2) begin
               base_lo_in = mem_q_ff;
            end
            if (cnt_ff == 3'd3) begin
               row_ptr_in = {mem_q_ff[3:0], base_lo_ff};
               clipped_in = raw_w_ff > 8'(fgr_pkg::WIDTH_CAP);
               width_in   = clipped_in ? 6'(fgr_pkg::WIDTH_CAP) : raw_w_ff[5:0];
               nbytes_in  = 3'((7'(width_in) + 7'd7) >> 3);
               stride_in  = raw_w_round[8:3];
               height_in  = cfg.glyph_height > 6'(fgr_pkg::HEIGHT_CAP) ?
                            6'(fgr_pkg::HEIGHT_CAP) : cfg.glyph_height;
               row_in     = 6'd0;
               cnt_in     = 3'd0;
               bits_in    = 32'd0;
               state_in   = height_in == 6'd0 ? fgr_pkg::ST_EMIT : fgr_pkg::ST_ROW;
            end
         end

         fgr_pkg::ST_ROW: begin
            if (cnt_ff != 3'd0) begin
               bits_in[{byte_idx, 3'b000} +: 8] = mem_q_ff;
            end
            if (cnt_ff == nbytes_ff) begin
               state_in = fgr_pkg::ST_EMIT;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end

         fgr_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.origin_col     = col0;
               rsp_in.origin_row     = row0;
               rsp_in.step_down_rows = rotated;
               rsp_in.pixel_mask     = bits_ff & width_mask & clip_mask;
               rsp_in.pixel_color    = cfg.text_color;
               rsp_in.status         = clipped_ff ? fgr_pkg::STATUS_CLIPPED :
                                                    fgr_pkg::STATUS_OK;
               rsp_in.last           = row_last;
               if (row_last) begin
                  if (cfg.orientation == fgr_pkg::ORIENT_HORIZ) begin
                     cur_col_in = cur_col_ff + 16'(width_ff) + 16'd1;
                  end else if (cfg.orientation == fgr_pkg::ORIENT_STACK) begin
                     cur_row_in = cur_row_ff + 16'(height_ff);
                  end else begin
                     cur_row_in = cur_row_ff - 16'(width_ff) - 16'd1;
                  end
                  state_in = fgr_pkg::ST_IDLE;
               end else begin
                  row_in     = row_ff + 6'd1;
                  row_ptr_in = row_ptr_ff + fgr_pkg::FONT_AW'(stride_ff);
                  bits_in    = 32'd0;
                  cnt_in     = 3'd0;
                  state_in   = fgr_pkg::ST_ROW;
               end
            end
         end

         default: state_in = fgr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fgr_pkg::ST_IDLE;
         cnt_ff       <= 3'd0;
         row_ff       <= 6'd0;
         cur_col_ff   <= 16'd0;
         cur_row_ff   <= 16'd0;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ptr_ff <= entry_ptr_in;
      row_ptr_ff   <= row_ptr_in;
      raw_w_ff     <= raw_w_in;
      base_lo_ff   <= base_lo_in;
      width_ff     <= width_in;
      nbytes_ff    <= nbytes_in;
      stride_ff    <= stride_in;
      height_ff    <= height_in;
      clipped_ff   <= clipped_in;
      bits_ff      <= bits_in;
      rsp_ff       <= rsp_in;
   end

endmodule
